[hw/rtl/trial_division_prime_check_defines.svh]
// assertion macros shared by the trial division prime checker
// expects clk and arst_n in the scope of every use
`ifndef TRIAL_DIVISION_PRIME_CHECK_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_CHECK_DEFINES_SVH

// same-cycle implication, quiet while reset is applied
`define TDPC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdpc assertion failed");

// next-cycle implication, quiet while reset is applied
`define TDPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdpc assertion failed");

`endif

[hw/rtl/tdpc_pkg.sv]
// shared types and constants of the trial division prime checker
// no dependencies
`timescale 1ns / 1ps

package tdpc_pkg;

	localparam int unsigned VALUE_WIDTH = 32;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIVIDE,
		ST_REM,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;     // take an input beat
		logic div_start;    // clear remainder, load bit counter
		logic div_step;     // one restoring division step
		logic advance;      // next divisor, update its square
		logic set_verdict;  // capture prime flag
		logic verdict;
		logic emit;         // load output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_fire;
		logic bad;          // value at most one or negative
		logic sq_over;      // divisor squared exceeds value
		logic div_last;     // last division step
		logic rem_zero;
		logic out_free;     // output register can take a beat
	} sts_t;

endpackage

[hw/rtl/tdpc_in_if.sv]
// input channel: value and end-of-sequence flag
// depends on tdpc_pkg for the default width
`timescale 1ns / 1ps

interface tdpc_in_if #(
	parameter int unsigned VALUE_WIDTH = tdpc_pkg::VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          seq_end;

	modport source (output valid, output value, output seq_end, input ready);
	modport sink (input valid, input value, input seq_end, output ready);
endinterface

[hw/rtl/tdpc_out_if.sv]
// output channel: prime flags and end-of-sequence copy
// no dependencies
`timescale 1ns / 1ps

interface tdpc_out_if;
	logic valid;
	logic ready;
	logic item_prime;
	logic all_prime;
	logic result_end;

	modport source (output valid, output item_prime, output all_prime, output result_end,
		input ready);
	modport sink (input valid, input item_prime, input all_prime, input result_end,
		output ready);
endinterface

[hw/rtl/tdpc_datapath.sv]
// datapath: operand, divisor and its square, bit-serial remainder, output register
// depends on tdpc_pkg, tdpc_in_if, tdpc_out_if
`timescale 1ns / 1ps

module tdpc_datapath #(
	parameter int unsigned VALUE_WIDTH = tdpc_pkg::VALUE_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	tdpc_in_if.sink         din,
	tdpc_out_if.source      dout,
	input  tdpc_pkg::cmd_t  cmd,
	output tdpc_pkg::sts_t  sts
);
	localparam int unsigned MW = VALUE_WIDTH - 1;  // magnitude of a positive value
	localparam int unsigned CW = $clog2(MW);

	logic [MW-1:0]          n_q;
	logic [MW-1:0]          d_q;
	logic [VALUE_WIDTH-1:0] sq_q;
	logic [MW-1:0]          rem_q;
	logic [CW-1:0]          cnt_q;
	logic                   bad_q;
	logic                   end_q;
	logic                   verdict_q;

	logic                   out_valid_q;
	logic                   out_prime_q;
	logic                   out_all_q;
	logic                   out_end_q;
	logic                   running_q;

	logic                   in_bad;
	logic [VALUE_WIDTH-1:0] trial;
	logic [VALUE_WIDTH-1:0] diff;
	logic                   ge;
	logic [MW-1:0]          rem_next;
	logic                   all_next;

	assign in_bad = din.value[VALUE_WIDTH-1] || (din.value[MW-1:0] <= MW'(1));

	// shift in the next dividend bit, subtract if it fits
	assign trial    = {rem_q, n_q[cnt_q]};
	assign ge       = trial >= {1'b0, d_q};
	assign diff     = trial - {1'b0, d_q};
	assign rem_next = ge ? diff[MW-1:0] : trial[MW-1:0];

	assign all_next = running_q & verdict_q;

	assign din.ready = cmd.in_ready;

	assign sts.in_fire  = din.valid && din.ready;
	assign sts.bad      = bad_q;
	assign sts.sq_over  = sq_q > {1'b0, n_q};
	assign sts.div_last = cnt_q == '0;
	assign sts.rem_zero = rem_q == '0;
	assign sts.out_free = !out_valid_q || dout.ready;

	assign dout.valid      = out_valid_q;
	assign dout.item_prime = out_prime_q;
	assign dout.all_prime  = out_all_q;
	assign dout.result_end = out_end_q;

	always_ff @(posedge clk) begin
		if (sts.in_fire) begin
			n_q   <= din.value[MW-1:0];
			bad_q <= in_bad;
			end_q <= din.seq_end;
			d_q   <= MW'(2);
			sq_q  <= VALUE_WIDTH'(4);
		end else if (cmd.advance) begin
			// (d+1)^2 = d^2 + 2d + 1
			sq_q <= sq_q + {d_q, 1'b0} + VALUE_WIDTH'(1);
			d_q  <= d_q + MW'(1);
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			cnt_q <= CW'(MW - 1);
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.set_verdict) begin
			verdict_q <= cmd.verdict;
		end
		if (cmd.emit) begin
			out_prime_q <= verdict_q;
			out_all_q   <= all_next;
			out_end_q   <= end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			running_q   <= 1'b1;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				running_q   <= end_q ? 1'b1 : all_next;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/tdpc_ctrl.sv]
// controller: sequences divisor tests and division steps for one value
// depends on tdpc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "trial_division_prime_check_defines.svh"

module tdpc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  tdpc_pkg::sts_t  sts,
	output tdpc_pkg::cmd_t  cmd
);
	tdpc_pkg::state_t state_q;
	tdpc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tdpc_pkg::ST_IDLE: begin
				if (sts.in_fire) state_d = tdpc_pkg::ST_TEST;
			end
			tdpc_pkg::ST_TEST: begin
				if (sts.bad || sts.sq_over) state_d = tdpc_pkg::ST_DONE;
				else state_d = tdpc_pkg::ST_DIVIDE;
			end
			tdpc_pkg::ST_DIVIDE: begin
				if (sts.div_last) state_d = tdpc_pkg::ST_REM;
			end
			tdpc_pkg::ST_REM: begin
				if (sts.rem_zero) state_d = tdpc_pkg::ST_DONE;
				else state_d = tdpc_pkg::ST_TEST;
			end
			tdpc_pkg::ST_DONE: begin
				if (sts.out_free) state_d = tdpc_pkg::ST_IDLE;
			end
			default: begin
				state_d = tdpc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			tdpc_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			tdpc_pkg::ST_TEST: begin
				priority if (sts.bad) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b0;
				end else if (sts.sq_over) begin
					// no divisor up to the square root
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			tdpc_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			tdpc_pkg::ST_REM: begin
				if (sts.rem_zero) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict     = 1'b0;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			tdpc_pkg::ST_DONE: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`TDPC_ASSERT_NEXT(a_bad_ends_test, state_q == tdpc_pkg::ST_TEST && sts.bad,
		state_q == tdpc_pkg::ST_DONE)
	`TDPC_ASSERT_NEXT(a_divide_holds, state_q == tdpc_pkg::ST_DIVIDE && !sts.div_last,
		state_q == tdpc_pkg::ST_DIVIDE)
	`TDPC_ASSERT_NEXT(a_done_waits, state_q == tdpc_pkg::ST_DONE && !sts.out_free,
		state_q == tdpc_pkg::ST_DONE)
	`TDPC_ASSERT_IMP(a_ready_only_idle, cmd.in_ready, state_q == tdpc_pkg::ST_IDLE && !cmd.emit)

endmodule

[hw/rtl/trial_division_prime_check.sv]
// top level of the trial division prime checker
// depends on tdpc_pkg, tdpc_in_if, tdpc_out_if, tdpc_ctrl, tdpc_datapath
`timescale 1ns / 1ps

// channel  dir  payload                              beat
// din      in   value (signed), seq_end              valid & ready
// dout     out  item_prime, all_prime, result_end    valid & ready
//
// sequence: from idle, each divisor tried takes a test, the bit-serial division steps
//   and a remainder check; a prime ends on a test, a composite on a zero remainder,
//   then the output waits; about 46340 divisors are tried for a 32-bit prime.
// values at most one, and negative values, go from the test straight to the output state.
// reset: asynchronous, clears the controller, the output valid and the
//   running all-prime flag (set to one).
// stalls: a finished beat waits in the output register; the next value is
//   taken while it waits, and its result waits until that beat is gone.

module trial_division_prime_check #(
	parameter int unsigned VALUE_WIDTH = tdpc_pkg::VALUE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	tdpc_in_if.sink     din,
	tdpc_out_if.source  dout
);
	// command and status between controller and datapath
	tdpc_pkg::cmd_t cmd;
	tdpc_pkg::sts_t sts;

	// state machine: idle, divisor test, division steps, remainder check, output
	tdpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// operand, divisor, running square, remainder and output register
	tdpc_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

[sim/tb_trial_division_prime_check.sv]
// self-checking testbench of the trial division prime checker: directed table, then random sequences
// depends on tdpc_pkg, tdpc_in_if, tdpc_out_if and trial_division_prime_check
`timescale 1ns / 1ps

module tb_trial_division_prime_check;

	localparam int unsigned VW = tdpc_pkg::VALUE_WIDTH;

	// the largest positive prime costs about 46340 divisors, far the longest check;
	// the random beats stay small or are rejected early
	localparam longint LIMIT_CYCLES = 12_000_000;
	localparam int     DRAIN_CYCLES = 64;
	localparam int     BEATS_PER_PHASE = 25;
	localparam int     DIRECTED_ROWS = 21;

	typedef struct packed {
		logic item_prime;
		logic all_prime;
		logic result_end;
	} verdict_t;

	// one expected output beat, with the value that caused it for the log
	typedef struct packed {
		logic signed [VW-1:0] value;
		verdict_t             verdict;
	} awaited_t;

	// directed stimulus row; typed rows carry their answer, the rest use the predictor
	typedef struct packed {
		logic signed [VW-1:0] value;
		logic                 last_flag;
		logic                 typed;
		verdict_t             want;
	} stim_row_t;

	localparam verdict_t FROM_PREDICTOR = '{1'b0, 1'b0, 1'b0};
	localparam verdict_t PRIME_SEQ_END  = '{1'b1, 1'b1, 1'b1};
	localparam verdict_t NOT_PRIME_END  = '{1'b0, 1'b0, 1'b1};

	// every typed row closes a sequence, so the running flag is known going in
	localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		// smallest prime right after reset
		'{32'sd2, 1'b1, 1'b1, PRIME_SEQ_END},
		// zero, one and negatives are never prime
		'{32'sd0, 1'b1, 1'b1, NOT_PRIME_END},
		'{32'sd1, 1'b1, 1'b1, NOT_PRIME_END},
		'{-32'sd1, 1'b1, 1'b1, NOT_PRIME_END},
		'{32'sh8000_0000, 1'b1, 1'b1, NOT_PRIME_END},
		// all-prime sequence
		'{32'sd3, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'sd5, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'sd7, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'sd11, 1'b1, 1'b0, FROM_PREDICTOR},
		// a square of a prime breaks the running flag mid-sequence
		'{32'sd13, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'sd4, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'sd17, 1'b1, 1'b0, FROM_PREDICTOR},
		// divisor squared equal to the value
		'{32'sd9, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'sd25, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'sd49, 1'b1, 1'b0, FROM_PREDICTOR},
		// negative value inside a sequence
		'{32'sd97, 1'b0, 1'b0, FROM_PREDICTOR},
		'{-32'sd7, 1'b1, 1'b0, FROM_PREDICTOR},
		// large positive composites, quick to reject
		'{32'sh4000_0000, 1'b1, 1'b0, FROM_PREDICTOR},
		'{32'sh7fff_fffe, 1'b1, 1'b0, FROM_PREDICTOR},
		'{32'sh5555_5555, 1'b1, 1'b0, FROM_PREDICTOR},
		// largest positive value is prime: the bound must not overflow
		'{32'sh7fff_ffff, 1'b1, 1'b1, PRIME_SEQ_END}
	};

	logic   clk;
	logic   arst_n;
	longint cycle_count = 0;
	int     fault_count = 0;
	int     result_count = 0;
	int     send_idle_pct;
	int     recv_stall_pct;

	// predictor state and the expectations it has produced
	bit       seq_all_prime;
	awaited_t awaited_verdicts[$];

	tdpc_in_if #(.VALUE_WIDTH(VW)) din_bus ();
	tdpc_out_if                    dout_bus ();

	trial_division_prime_check #(
		.VALUE_WIDTH(VW)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_bus),
		.dout  (dout_bus)
	);

	// 12 ns period
	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// trial division on the magnitude; d <= n / d keeps the bound free of overflow
	function automatic bit is_prime_value(input logic signed [VW-1:0] v);
		logic [VW-1:0]   mag;
		longint unsigned n;
		longint unsigned d;
		if (v < 2) begin
			return 1'b0;
		end
		mag = v;
		n = mag;
		for (d = 2; d <= n / d; d++) begin
			if (n % d == 0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// result of one accepted beat; updates the running all-prime flag
	function automatic verdict_t predict_verdict(input logic signed [VW-1:0] v,
		input bit last_flag);
		verdict_t vd;
		vd.item_prime = is_prime_value(v);
		vd.all_prime  = seq_all_prime & vd.item_prime;
		vd.result_end = last_flag;
		seq_all_prime = last_flag ? 1'b1 : vd.all_prime;
		return vd;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// called just after a falling edge; returns just after the falling edge that
	// follows the beat, so valid is only ever written once per time step
	task automatic send_beat(input logic signed [VW-1:0] v, input bit last_flag,
		input bit typed, input verdict_t want);
		awaited_t aw;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			din_bus.valid <= 1'b0;
			@(negedge clk);
		end
		din_bus.valid   <= 1'b1;
		din_bus.value   <= v;
		din_bus.seq_end <= last_flag;
		do begin
			@(posedge clk);
		end while (!din_bus.ready);
		// beat taken: predictor runs even for typed rows to keep its flag in step
		aw.value   = v;
		aw.verdict = predict_verdict(v, last_flag);
		if (typed) begin
			aw.verdict = want;
		end
		awaited_verdicts.push_back(aw);
		@(negedge clk);
	endtask

	// receiver: ready low from time zero, then changes on the falling edge only
	initial begin
		dout_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n) begin
				dout_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// output monitor: each beat against the oldest expectation
	always @(posedge clk) begin
		awaited_t aw;
		verdict_t got;
		if (arst_n && dout_bus.valid && dout_bus.ready) begin
			got = '{dout_bus.item_prime, dout_bus.all_prime, dout_bus.result_end};
			if (awaited_verdicts.size() == 0) begin
				note_fault($sformatf("result %0d: unexpected beat prime %0b all %0b end %0b",
					result_count, got.item_prime, got.all_prime, got.result_end));
			end else begin
				aw = awaited_verdicts.pop_front();
				if (got !== aw.verdict) begin
					note_fault($sformatf(
						"result %0d value %0d: expected prime %0b all %0b end %0b, got %0b %0b %0b",
						result_count, aw.value, aw.verdict.item_prime, aw.verdict.all_prime,
						aw.verdict.result_end, got.item_prime, got.all_prime, got.result_end));
				end
			end
			result_count++;
		end
	end

	// watchdog
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("trial_division_prime_check verification failed");
		$finish;
	end

	initial begin
		int                   phase;
		int                   issued;
		int                   seq_len;
		int                   prime_pct;
		int                   i;
		logic signed [VW-1:0] v;
		logic [VW-1:0]        r;

		// known values on every input from time zero
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		seq_all_prime   = 1'b1;
		arst_n          = 1'b0;
		din_bus.valid   = 1'b0;
		din_bus.value   = '0;
		din_bus.seq_end = 1'b0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, no idling on either side
		for (i = 0; i < DIRECTED_ROWS; i++) begin
			send_beat(DIRECTED[i].value, DIRECTED[i].last_flag, DIRECTED[i].typed,
				DIRECTED[i].want);
		end

		// random sequences; phases: no idling, sender idle, receiver stalling, both
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			issued = 0;
			while (issued < BEATS_PER_PHASE) begin
				seq_len = $urandom_range(1, 6);
				// most sequences stay prime so the running flag survives several beats
				prime_pct = ($urandom_range(0, 3) != 0) ? 85 : 30;
				for (i = 0; i < seq_len; i++) begin
					if ($urandom_range(0, 99) < prime_pct) begin
						v = $urandom_range(2, 3000);
						while (!is_prime_value(v)) begin
							v++;
						end
					end else begin
						r = $urandom;
						case ($urandom_range(0, 4))
							0: v = $urandom_range(0, 4095);
							1: begin
								// negative, any magnitude
								r[VW-1] = 1'b1;
								v = r;
							end
							2: begin
								// large positive multiple of three, rejected at once
								r[VW-1] = 1'b0;
								v = r - (r % 3);
							end
							3: v = $urandom_range(0, 3);
							default: v = $urandom_range(4096, 65535);
						endcase
					end
					send_beat(v, i == seq_len - 1, 1'b0, FROM_PREDICTOR);
					issued++;
				end
			end
		end
		din_bus.valid <= 1'b0;

		// let every expected beat arrive, then watch a little longer for extras
		recv_stall_pct = 0;
		while (awaited_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0) begin
			$display("trial_division_prime_check verification clean");
		end else begin
			$display("trial_division_prime_check verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tdpc_pkg.sv
hw/rtl/tdpc_in_if.sv
hw/rtl/tdpc_out_if.sv
hw/rtl/tdpc_datapath.sv
hw/rtl/tdpc_ctrl.sv
hw/rtl/trial_division_prime_check.sv
sim/tb_trial_division_prime_check.sv
